// ===== sv/slpg_pkg.sv =====
// Shared types, constants and color tables for the status LED pattern generator.
// No dependencies; every other file imports this package.
package slpg_pkg;

	// Phase counter width; wraps modulo 2**PHASE_BITS
	localparam int PHASE_BITS = 32;
	localparam int CNT_W      = $clog2(PHASE_BITS);

	// Remainder of the phase: largest divisor is 255*10+24 = 2574
	localparam int REM_W  = 12;
	// Serial divider lanes: dividend below 60*50, divisor at most 50
	localparam int DIV_W  = 12;
	localparam int DCNT_W = $clog2(DIV_W);
	localparam int LEN_W  = 6;

	// Field widths
	localparam int CMD_W   = 3;
	localparam int STS_W   = 4;
	localparam int BAT_W   = 3;
	localparam int RGB565_W = 16;
	localparam int THEME_W = 3;
	localparam int CH_W    = 7;
	localparam int LVL_W   = 6;
	localparam int BG_W    = 8;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BLINK_GROUPS = 1'b0;
	localparam logic [BG_W-1:0] BLINK_GROUPS_RESET = 8'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK        = 3'd0,
		CMD_SET_STATUS  = 3'd1,
		CMD_SET_BATTERY = 3'd2,
		CMD_SET_IDLE    = 3'd3,
		CMD_SET_THEME   = 3'd4,
		CMD_PAUSE       = 3'd5,
		CMD_RESUME      = 3'd6
	} cmd_t;

	localparam logic [STS_W-1:0] STS_BOOT        = 4'd0;
	localparam logic [STS_W-1:0] STS_IDLE        = 4'd1;
	localparam logic [STS_W-1:0] STS_RUNNING     = 4'd2;
	localparam logic [STS_W-1:0] STS_FLASH_BUSY  = 4'd3;
	localparam logic [STS_W-1:0] STS_FLASH_OK    = 4'd4;
	localparam logic [STS_W-1:0] STS_MAINTENANCE = 4'd5;
	localparam logic [STS_W-1:0] STS_SD_BUSY     = 4'd6;
	localparam logic [STS_W-1:0] STS_ERROR       = 4'd7;
	localparam logic [STS_W-1:0] STS_DARK        = 4'd8;

	localparam logic [BAT_W-1:0] BAT_NONE     = 3'd0;
	localparam logic [BAT_W-1:0] BAT_CHARGING = 3'd1;
	localparam logic [BAT_W-1:0] BAT_FULL     = 3'd2;
	localparam logic [BAT_W-1:0] BAT_LOW      = 3'd3;
	localparam logic [BAT_W-1:0] BAT_CRITICAL = 3'd4;

	localparam logic [THEME_W-1:0] THEME_STATIC    = 3'd0;
	localparam logic [THEME_W-1:0] THEME_FIRST_PAL = 3'd1;
	localparam logic [THEME_W-1:0] THEME_LAST_PAL  = 3'd5;

	localparam logic [LVL_W-1:0] IDLE_LEVEL_RESET = 6'd44;

	// Blink timing
	localparam int AMBER_PERIOD = 80;
	localparam int AMBER_ON     = 20;
	localparam int BREATH_PERIOD = 20;
	localparam int BREATH_HALF  = 10;
	localparam int FLASH_PERIOD = 20;
	localparam int FLASH_ON     = 10;
	localparam int GROUP_STEP   = 10;
	localparam int GROUP_ON     = 5;
	localparam int GROUP_GAP    = 24;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SEG,
		S_PROD,
		S_GRP,
		S_DIV,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Stored mode that a tick is rendered from
	typedef struct packed {
		logic [STS_W-1:0]   status;
		logic [BAT_W-1:0]   battery;
		logic [THEME_W-1:0] theme;
		logic [BG_W-1:0]    blink_groups;
		logic [LVL_W-1:0]   idle_red;
		logic [LVL_W-1:0]   idle_green;
		logic [LVL_W-1:0]   idle_blue;
	} tick_ctx_t;

	// Palette interpolation results, channel 0 red, 1 green, 2 blue
	typedef struct packed {
		logic [2:0][LVL_W-1:0] base;
		logic [2:0][DIV_W-1:0] quot;
		logic [2:0]            neg;
	} lerp_t;

	localparam rgb_t RGB_ORANGE = '{red: 7'd60, green: 7'd20, blue: 7'd0};
	localparam rgb_t RGB_GREEN  = '{red: 7'd0,  green: 7'd56, blue: 7'd0};
	localparam rgb_t RGB_AMBER  = '{red: 7'd60, green: 7'd34, blue: 7'd0};

	localparam rgb_t STATUS_RGB [8] = '{
		'{red: 7'd30, green: 7'd14, blue: 7'd46},
		'{red: 7'd0,  green: 7'd0,  blue: 7'd0},
		'{red: 7'd48, green: 7'd0,  blue: 7'd48},
		'{red: 7'd0,  green: 7'd0,  blue: 7'd64},
		'{red: 7'd0,  green: 7'd0,  blue: 7'd64},
		'{red: 7'd0,  green: 7'd48, blue: 7'd48},
		'{red: 7'd60, green: 7'd18, blue: 7'd36},
		'{red: 7'd64, green: 7'd0,  blue: 7'd0}
	};

	// Red level 64*(20+8*t)/100 for the breathing ramp step t
	localparam logic [CH_W-1:0] BREATH_RED [11] = '{
		7'd12, 7'd17, 7'd23, 7'd28, 7'd33, 7'd38, 7'd43, 7'd48, 7'd53, 7'd58, 7'd64
	};

	localparam logic [LEN_W-1:0] SEG_LEN [5] = '{6'd50, 6'd45, 6'd45, 6'd35, 6'd45};

	// Five key colors per palette theme
	localparam logic [LVL_W-1:0] PAL [5][5][3] = '{
		'{'{6'd21, 6'd48, 6'd58}, '{6'd58, 6'd40, 6'd43}, '{6'd60, 6'd60, 6'd60},
		  '{6'd58, 6'd40, 6'd43}, '{6'd21, 6'd48, 6'd58}},
		'{'{6'd8,  6'd28, 6'd8},  '{6'd36, 6'd45, 6'd5},  '{6'd50, 6'd58, 6'd42},
		  '{6'd38, 6'd48, 6'd5},  '{6'd8,  6'd28, 6'd8}},
		'{'{6'd60, 6'd7,  6'd9},  '{6'd30, 6'd30, 6'd32}, '{6'd60, 6'd60, 6'd60},
		  '{6'd30, 6'd30, 6'd32}, '{6'd60, 6'd7,  6'd9}},
		'{'{6'd0,  6'd55, 6'd60}, '{6'd60, 6'd0,  6'd54}, '{6'd60, 6'd50, 6'd0},
		  '{6'd0,  6'd60, 6'd18}, '{6'd0,  6'd55, 6'd60}},
		'{'{6'd58, 6'd8,  6'd23}, '{6'd58, 6'd58, 6'd58}, '{6'd25, 6'd50, 6'd10},
		  '{6'd58, 6'd58, 6'd58}, '{6'd58, 6'd8,  6'd23}}
	};

	// Scale an 8-bit channel to 0..60: x*60/255 via reciprocal shift
	function automatic logic [LVL_W-1:0] scale_to_60(input logic [7:0] x);
		logic [14:0] n;
		logic [14:0] q;
		n = 15'({x, 6'b0}) - 15'({x, 2'b0});
		q = (n + (n >> 8) + 15'd1) >> 8;
		return q[LVL_W-1:0];
	endfunction

endpackage

// ===== sv/slpg_if.sv =====
// Handshake channels of the status LED pattern generator: commands in, colors out.
// Depends on slpg_pkg for field widths.
interface slpg_cmd_if;
	import slpg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [STS_W-1:0]      status_code;
	logic [BAT_W-1:0]      battery_code;
	logic [RGB565_W-1:0]   idle_rgb565;
	logic [THEME_W-1:0]    theme_code;

	modport source (output valid, command, status_code, battery_code, idle_rgb565, theme_code,
		input ready);
	modport sink (input valid, command, status_code, battery_code, idle_rgb565, theme_code,
		output ready);
endinterface

interface slpg_rgb_if;
	import slpg_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== sv/slpg_modser.sv =====
// Bit-serial remainder of the phase by a small divisor, one phase bit per cycle.
// Depends on slpg_pkg.
module slpg_modser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [slpg_pkg::PHASE_BITS-1:0] dividend,
	input  logic [slpg_pkg::REM_W-1:0]  divisor,
	output logic                        done,
	output logic [slpg_pkg::REM_W-1:0]  rem
);
	import slpg_pkg::*;

	logic [PHASE_BITS-1:0] shift_q;
	logic [REM_W-1:0]      divisor_q;
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        trial_sub;

	// Shift the next phase bit into the partial remainder, subtract when it fits
	always_comb begin
		trial     = {rem_q, shift_q[PHASE_BITS-1]};
		trial_sub = trial;
		if (trial >= {1'b0, divisor_q}) begin
			trial_sub = trial - {1'b0, divisor_q};
		end
	end

	// Control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PHASE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifter and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[PHASE_BITS-2:0], 1'b0};
			rem_q   <= trial_sub[REM_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== sv/slpg_divlane.sv =====
// One lane of a restoring bit-serial divider: quotient and remainder of a small word.
// Depends on slpg_pkg.
module slpg_divlane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [slpg_pkg::DIV_W-1:0] dividend,
	input  logic [slpg_pkg::LEN_W-1:0] divisor,
	output logic                       done,
	output logic [slpg_pkg::DIV_W-1:0] quot,
	output logic [slpg_pkg::LEN_W-1:0] rem
);
	import slpg_pkg::*;

	logic [DIV_W-1:0]  quot_q;
	logic [LEN_W-1:0]  divisor_q;
	logic [LEN_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [LEN_W:0]    trial;
	logic              fits;

	// Bring down the next dividend bit; a fit sets the quotient bit
	always_comb begin
		trial = {rem_q, quot_q[DIV_W-1]};
		fits  = (trial >= {1'b0, divisor_q});
	end

	// Control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			divisor_q <= divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			if (fits) begin
				rem_q <= LEN_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[LEN_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== sv/slpg_colour.sv =====
// Color selection for one tick: battery overlay, idle palette or static color, status blinks.
// Depends on slpg_pkg; fed by the phase remainder and the divider lanes.
module slpg_colour (
	input  slpg_pkg::tick_ctx_t        ctx,
	input  logic [slpg_pkg::REM_W-1:0] p,
	input  logic [slpg_pkg::LEN_W-1:0] grp_rem,
	input  slpg_pkg::lerp_t            lerp,
	output slpg_pkg::rgb_t             colour
);
	import slpg_pkg::*;

	logic             overlay;
	logic             theme_on;
	logic [REM_W-1:0] group_len;
	logic             group_on;
	logic [3:0]       ramp_idx;
	logic [2:0][LVL_W-1:0] lvl;
	rgb_t             lerp_rgb;
	rgb_t             idle_rgb;
	rgb_t             ramp_rgb;

	// Mode decode
	always_comb begin
		overlay   = ((ctx.status == STS_IDLE) || (ctx.status == STS_RUNNING))
			&& (ctx.battery >= BAT_CHARGING) && (ctx.battery <= BAT_CRITICAL);
		theme_on  = (ctx.theme >= THEME_FIRST_PAL) && (ctx.theme <= THEME_LAST_PAL);
		group_len = REM_W'({ctx.blink_groups, 3'b0}) + REM_W'({ctx.blink_groups, 1'b0});
		group_on  = (p < group_len) && (grp_rem < LEN_W'(GROUP_ON));
		if (p < REM_W'(BREATH_HALF)) begin
			ramp_idx = p[3:0];
		end else begin
			ramp_idx = 4'(REM_W'(BREATH_PERIOD) - p);
		end
	end

	// Finish the interpolation: base plus or minus the truncated quotient
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if (lerp.neg[ch]) begin
				lvl[ch] = lerp.base[ch] - lerp.quot[ch][LVL_W-1:0];
			end else begin
				lvl[ch] = lerp.base[ch] + lerp.quot[ch][LVL_W-1:0];
			end
		end
		lerp_rgb = '{red: {1'b0, lvl[0]}, green: {1'b0, lvl[1]}, blue: {1'b0, lvl[2]}};
		idle_rgb = '{red: {1'b0, ctx.idle_red}, green: {1'b0, ctx.idle_green},
			blue: {1'b0, ctx.idle_blue}};
		ramp_rgb = '{red: BREATH_RED[ramp_idx], green: '0, blue: '0};
	end

	// Pick the color; the battery overlay wins in idle and running
	always_comb begin
		priority if (overlay && (ctx.battery == BAT_CHARGING)) begin
			colour = RGB_ORANGE;
		end else if (overlay && (ctx.battery == BAT_FULL)) begin
			colour = RGB_GREEN;
		end else if (overlay && (ctx.battery == BAT_LOW)) begin
			colour = (p < REM_W'(AMBER_ON)) ? RGB_AMBER : '0;
		end else if (overlay) begin
			colour = ramp_rgb;
		end else if (ctx.status == STS_IDLE) begin
			colour = theme_on ? lerp_rgb : idle_rgb;
		end else if (ctx.status >= STS_DARK) begin
			colour = '0;
		end else if (ctx.status == STS_FLASH_BUSY) begin
			colour = (p < REM_W'(FLASH_ON)) ? STATUS_RGB[ctx.status[2:0]] : '0;
		end else if ((ctx.status == STS_MAINTENANCE) || (ctx.status == STS_SD_BUSY)
			|| (ctx.status == STS_ERROR)) begin
			colour = group_on ? STATUS_RGB[ctx.status[2:0]] : '0;
		end else begin
			colour = STATUS_RGB[ctx.status[2:0]];
		end
	end

endmodule

// ===== sv/status_led_pattern_generator_top.sv =====
// A tick runs the sequencer from S_IDLE through S_MOD, where the bit-serial phase remainder
// takes one of PHASE_BITS phase bits per cycle, to S_EMIT for blink, solid and overlay colors;
// grouped blinks pass S_GRP and palette themes S_SEG and S_PROD, then S_DIV, where the 12-step
// serial divider lanes run. No new command is taken until the word is loaded; a stalled word
// holds the next tick's word in S_EMIT. Commands other than an unpaused tick give no word.
// arst_n clears mode, phase and handshake state at once; idle color resets to 44,44,44.
module status_led_pattern_generator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	slpg_cmd_if.sink                     cmd,
	slpg_rgb_if.source                   rgb,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slpg_pkg::PADDR_W-1:0] paddr,
	input  logic [slpg_pkg::PDATA_W-1:0] pwdata,
	output logic [slpg_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import slpg_pkg::*;

	seq_state_t state_q, state_d;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_inc;
	logic [STS_W-1:0]      status_q;
	logic [BAT_W-1:0]      battery_q;
	logic [THEME_W-1:0]    theme_q;
	logic                  paused_q;
	logic [LVL_W-1:0]      idle_red_q, idle_green_q, idle_blue_q;
	logic [BG_W-1:0]       blink_groups_q;

	logic [1:0]            seg_q;
	logic [LEN_W-1:0]      pos_q;
	logic [2:0][LVL_W-1:0] base_q;
	logic [2:0]            neg_q;

	logic                  out_valid_q;
	rgb_t                  out_q;

	logic cmd_ready, cmd_accept, tick_go;
	logic mod_start, div_start, div_grp, out_load;
	logic overlay, theme_on, lerp_path, grp_path;
	logic [2:0]            pal_k;
	logic [LEN_W-1:0]      len;
	logic [REM_W-1:0]      mod_div;
	logic                  mod_done;
	logic [REM_W-1:0]      mod_rem;
	logic [1:0]            seg_d;
	logic [LEN_W-1:0]      pos_d;
	logic [2:0][LVL_W-1:0] base_d;
	logic [2:0]            neg_d;
	logic [2:0][DIV_W-1:0] lane_dvd;
	logic [2:0][LEN_W-1:0] lane_dvs;
	logic [2:0]            lane_done;
	logic [2:0][DIV_W-1:0] lane_quot;
	logic [2:0][LEN_W-1:0] lane_rem;
	logic                  cfg_write;
	tick_ctx_t             ctx;
	lerp_t                 lerp;
	rgb_t                  colour;

	// Mode decode and remainder divisor for the coming tick
	always_comb begin
		overlay   = ((status_q == STS_IDLE) || (status_q == STS_RUNNING))
			&& (battery_q >= BAT_CHARGING) && (battery_q <= BAT_CRITICAL);
		theme_on  = (theme_q >= THEME_FIRST_PAL) && (theme_q <= THEME_LAST_PAL);
		pal_k     = theme_on ? (theme_q - THEME_FIRST_PAL) : 3'd0;
		len       = SEG_LEN[pal_k];
		lerp_path = (status_q == STS_IDLE) && !overlay && theme_on;
		grp_path  = (status_q == STS_MAINTENANCE) || (status_q == STS_SD_BUSY)
			|| (status_q == STS_ERROR);
		priority if (overlay && (battery_q == BAT_LOW)) begin
			mod_div = REM_W'(AMBER_PERIOD);
		end else if (overlay && (battery_q == BAT_CRITICAL)) begin
			mod_div = REM_W'(BREATH_PERIOD);
		end else if (lerp_path) begin
			mod_div = REM_W'({len, 2'b00});
		end else if (status_q == STS_FLASH_BUSY) begin
			mod_div = REM_W'(FLASH_PERIOD);
		end else if (grp_path) begin
			mod_div = REM_W'({blink_groups_q, 3'b0}) + REM_W'({blink_groups_q, 1'b0})
				+ REM_W'(GROUP_GAP);
		end else begin
			mod_div = REM_W'(AMBER_PERIOD);
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mod_start = 1'b0;
		div_start = 1'b0;
		div_grp   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (tick_go) begin
					mod_start = 1'b1;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					priority if (lerp_path) begin
						state_d = S_SEG;
					end else if (grp_path) begin
						state_d = S_GRP;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_SEG: begin
				state_d = S_PROD;
			end
			S_PROD: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_GRP: begin
				div_start = 1'b1;
				div_grp   = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (lane_done[0]) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || rgb.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cmd.ready  = cmd_ready;
	assign cmd_accept = cmd.valid && cmd_ready;
	assign tick_go    = cmd_accept && (cmd.command == CMD_TICK) && !paused_q;
	assign phase_inc  = phase_q + PHASE_BITS'(1);

	// Apply commands to the stored mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			status_q     <= STS_BOOT;
			battery_q    <= BAT_NONE;
			theme_q      <= THEME_STATIC;
			paused_q     <= 1'b0;
			idle_red_q   <= IDLE_LEVEL_RESET;
			idle_green_q <= IDLE_LEVEL_RESET;
			idle_blue_q  <= IDLE_LEVEL_RESET;
		end else if (cmd_accept) begin
			unique case (cmd.command)
				CMD_TICK: begin
					if (!paused_q) begin
						phase_q <= phase_inc;
					end
				end
				CMD_SET_STATUS: begin
					status_q <= cmd.status_code;
					phase_q  <= '0;
				end
				CMD_SET_BATTERY: begin
					if (cmd.battery_code != battery_q) begin
						battery_q <= cmd.battery_code;
						phase_q   <= '0;
					end
				end
				CMD_SET_IDLE: begin
					idle_red_q   <= scale_to_60({cmd.idle_rgb565[15:11], 3'b0});
					idle_green_q <= scale_to_60({cmd.idle_rgb565[10:5], 2'b0});
					idle_blue_q  <= scale_to_60({cmd.idle_rgb565[4:0], 3'b0});
				end
				CMD_SET_THEME: begin
					if (cmd.theme_code != theme_q) begin
						theme_q <= cmd.theme_code;
						phase_q <= '0;
					end
				end
				CMD_PAUSE: begin
					paused_q <= 1'b1;
				end
				CMD_RESUME: begin
					phase_q  <= '0;
					paused_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration register: zero groups reads as one
	assign cfg_write = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_groups_q <= BLINK_GROUPS_RESET;
		end else if (cfg_write && (paddr[2] == REG_BLINK_GROUPS)) begin
			blink_groups_q <= (pwdata[BG_W-1:0] == '0) ? BG_W'(1) : pwdata[BG_W-1:0];
		end
	end
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLINK_GROUPS) ? PDATA_W'(blink_groups_q) : '0;

	// Phase remainder unit
	slpg_modser u_modser (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (phase_inc),
		.divisor  (mod_div),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Split the palette position into segment and offset
	always_comb begin
		logic [REM_W-1:0] len1, len2, len3, off;
		len1 = REM_W'(len);
		len2 = len1 << 1;
		len3 = len2 + len1;
		priority if (mod_rem >= len3) begin
			seg_d = 2'd3;
			off   = len3;
		end else if (mod_rem >= len2) begin
			seg_d = 2'd2;
			off   = len2;
		end else if (mod_rem >= len1) begin
			seg_d = 2'd1;
			off   = len1;
		end else begin
			seg_d = 2'd0;
			off   = '0;
		end
		pos_d = LEN_W'(mod_rem - off);
	end

	// Key colors, difference magnitude and product for each channel
	always_comb begin
		logic [2:0]       seg_a, seg_b;
		logic [LVL_W-1:0] lvl_a, lvl_b, mag;
		seg_a = {1'b0, seg_q};
		seg_b = seg_a + 3'd1;
		for (int ch = 0; ch < 3; ch++) begin
			lvl_a = PAL[pal_k][seg_a][ch];
			lvl_b = PAL[pal_k][seg_b][ch];
			if (lvl_b >= lvl_a) begin
				mag       = lvl_b - lvl_a;
				neg_d[ch] = 1'b0;
			end else begin
				mag       = lvl_a - lvl_b;
				neg_d[ch] = 1'b1;
			end
			base_d[ch]   = lvl_a;
			lane_dvd[ch] = DIV_W'(mag) * DIV_W'(pos_q);
			lane_dvs[ch] = len;
		end
		// Lane 0 also takes the grouped-blink remainder by ten
		if (div_grp) begin
			lane_dvd[0] = DIV_W'(mod_rem);
			lane_dvs[0] = LEN_W'(GROUP_STEP);
		end
	end

	// Hold segment, offset and interpolation base between steps
	always_ff @(posedge clk) begin
		if (state_q == S_SEG) begin
			seg_q <= seg_d;
			pos_q <= pos_d;
		end
		if (state_q == S_PROD) begin
			base_q <= base_d;
			neg_q  <= neg_d;
		end
	end

	// Serial divider lanes, one per color channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		slpg_divlane u_divlane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (lane_dvd[ch]),
			.divisor  (lane_dvs[ch]),
			.done     (lane_done[ch]),
			.quot     (lane_quot[ch]),
			.rem      (lane_rem[ch])
		);
	end

	assign ctx = '{
		status:       status_q,
		battery:      battery_q,
		theme:        theme_q,
		blink_groups: blink_groups_q,
		idle_red:     idle_red_q,
		idle_green:   idle_green_q,
		idle_blue:    idle_blue_q
	};
	assign lerp = '{base: base_q, quot: lane_quot, neg: neg_q};

	slpg_colour u_colour (
		.ctx     (ctx),
		.p       (mod_rem),
		.grp_rem (lane_rem[0]),
		.lerp    (lerp),
		.colour  (colour)
	);

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rgb.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= colour;
		end
	end

	assign rgb.valid = out_valid_q;
	assign rgb.red   = out_q.red;
	assign rgb.green = out_q.green;
	assign rgb.blue  = out_q.blue;

endmodule

// ===== sv/slpg_checker.sv =====
// Port-level checks of the status LED pattern generator, bound to the top level.
// Depends on slpg_pkg and status_led_pattern_generator_top.
module slpg_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_ready,
	input logic [slpg_pkg::CMD_W-1:0]      cmd_command,
	input logic                            rgb_valid,
	input logic                            rgb_ready,
	input logic [slpg_pkg::CH_W-1:0]       rgb_red,
	input logic [slpg_pkg::CH_W-1:0]       rgb_green,
	input logic [slpg_pkg::CH_W-1:0]       rgb_blue
);
	import slpg_pkg::*;

	// A stalled color word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_ready |=> rgb_valid)
		else $error("color word dropped while stalled");

	// Drive levels never exceed 64
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> (rgb_red <= CH_W'(64)) && (rgb_green <= CH_W'(64))
			&& (rgb_blue <= CH_W'(64)))
		else $error("drive level above 64");

	// Mode commands produce no color word
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_command != CMD_TICK) |=> !$rose(rgb_valid))
		else $error("color word after a non-tick command");

	// A new word only follows a busy cycle of the sequencer
	a_word_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb_valid) |-> !$past(cmd_ready))
		else $error("color word without tick processing");

endmodule

bind status_led_pattern_generator_top slpg_port_checks u_slpg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_command (cmd.command),
	.rgb_valid   (rgb.valid),
	.rgb_ready   (rgb.ready),
	.rgb_red     (rgb.red),
	.rgb_green   (rgb.green),
	.rgb_blue    (rgb.blue)
);
